FILE: src/ptpg_pkg.sv
// ptpg_pkg: shared codes, types and helpers for the periodic pulse generator
`default_nettype none
package ptpg_pkg;

   localparam int unsigned TIME_W   = 63;
   localparam int unsigned WIDE_W   = 64;
   localparam int unsigned HALF_W   = 41;
   localparam int unsigned PERIOD_W = 42;
   localparam int unsigned ADDR_W   = 5;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_FIRE  = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   localparam logic [1:0] PAT_SILENT = 2'd0;
   localparam logic [1:0] PAT_SQUARE = 2'd1;

   localparam logic [ADDR_W-1:0] ADDR_PERIOD  = 5'd0;
   localparam logic [ADDR_W-1:0] ADDR_ANCHOR  = 5'd8;
   localparam logic [ADDR_W-1:0] ADDR_PATTERN = 5'd16;

   typedef struct packed {
      logic                start;
      logic [WIDE_W-1:0]   dividend;
      logic [PERIOD_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [PERIOD_W-1:0] rem;
      logic [31:0]         q_lo;
      logic [3:0]          q_mod10;
   } div_res_type;

   // one binary digit into a running value mod 10: (2*m + b) mod 10
   function automatic logic [3:0] mod10_step(input logic [3:0] m, input logic b);
      logic [4:0] v;
      v = {m, b};
      if (v >= 5'd10) begin
         v = v - 5'd10;
      end
      return v[3:0];
   endfunction

endpackage
`default_nettype wire

FILE: src/ptpg_if.sv
// ptpg_if: event and result channel interfaces
`default_nettype none
interface ptpg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [62:0] now_ns;
   logic        clock_valid;
   logic        arm_accepted;
   modport source(output valid, opcode, now_ns, clock_valid, arm_accepted, input ready);
   modport sink(input valid, opcode, now_ns, clock_valid, arm_accepted, output ready);
endinterface

interface ptpg_rsp_if;
   logic        valid;
   logic        ready;
   logic        start_ok;
   logic        is_running;
   logic        pin_level;
   logic [62:0] target_ns;
   logic [62:0] fired_target_ns;
   logic        fired_valid;
   logic [62:0] cycle_count;
   logic [62:0] miss_count;
   modport source(output valid, start_ok, is_running, pin_level, target_ns,
                  fired_target_ns, fired_valid, cycle_count, miss_count, input ready);
   modport sink(input valid, start_ok, is_running, pin_level, target_ns,
                fired_target_ns, fired_valid, cycle_count, miss_count, output ready);
endinterface
`default_nettype wire

FILE: src/ptp_aligned_periodic_pulse_generator_top.sv
// ptp_aligned_periodic_pulse_generator_top: sequencer, state and register port
//
//   channel   | direction | handshake           | contents
//   req_ch    | in        | valid / ready       | opcode, now_ns, clock_valid, arm_accepted
//   rsp_ch    | out       | valid / ready       | status, targets and counters
//   apb       | in        | psel/penable/pready | period, anchor time, pattern
//
// one transaction at a time; ready is high only when no transaction is in work.
// a start runs the multiply and align steps, an anchor division when the anchor needs one,
// then a slot division; a fire runs the multiply and fire steps, plus a catch-up division
// when the next target is already past and a mod-10 pass on a catch-up with a marker
// pattern; others go straight to the result. the divider yields one quotient bit per cycle.
// reset is synchronous; a stalled result holds in the final state until taken.
`default_nettype none
module ptp_aligned_periodic_pulse_generator_top #(
   parameter logic [31:0] DEFAULT_PERIOD_US = 32'd1000
) (
   input  wire                         clock,
   input  wire                         reset,
   ptpg_req_if.sink                    req_ch,
   ptpg_rsp_if.source                  rsp_ch,
   input  wire                         psel,
   input  wire                         penable,
   input  wire                         pwrite,
   input  wire  [ptpg_pkg::ADDR_W-1:0] paddr,
   input  wire  [63:0]                 pwdata,
   output logic [63:0]                 prdata,
   output logic                        pready
);
   import ptpg_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_MUL_A    = 4'd1;
   localparam logic [3:0] S_MUL_B    = 4'd2;
   localparam logic [3:0] S_ALIGN    = 4'd3;
   localparam logic [3:0] S_ALIGN2   = 4'd4;
   localparam logic [3:0] S_DIV_ALN  = 4'd5;
   localparam logic [3:0] S_SLOT     = 4'd6;
   localparam logic [3:0] S_DIV_SLOT = 4'd7;
   localparam logic [3:0] S_FIRE     = 4'd8;
   localparam logic [3:0] S_FIRE2    = 4'd9;
   localparam logic [3:0] S_DIV_MISS = 4'd10;
   localparam logic [3:0] S_MOD10    = 4'd11;
   localparam logic [3:0] S_FIN      = 4'd12;
   localparam logic [3:0] S_RESP     = 4'd13;

   logic [3:0] state_ff, state_in;

   // configuration
   logic [31:0]       cfg_period_ff, cfg_period_in;
   logic [TIME_W-1:0] cfg_anchor_ff, cfg_anchor_in;
   logic [1:0]        cfg_pattern_ff, cfg_pattern_in;

   // architectural state
   logic              running_ff, running_in;
   logic              pin_ff, pin_in;
   logic [WIDE_W-1:0] target_ff, target_in;
   logic [3:0]        slot_ff, slot_in;
   logic [WIDE_W-1:0] fires_ff, fires_in;
   logic [WIDE_W-1:0] missed_ff, missed_in;
   logic [31:0]       aperiod_ff, aperiod_in;
   logic [1:0]        apattern_ff, apattern_in;

   // per-transaction work registers
   logic [1:0]        op_ff, op_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              arm_ff, arm_in;
   logic [31:0]       per_ff, per_in;
   logic [HALF_W-1:0] mtmp_ff, mtmp_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic [WIDE_W-1:0] ahead_ff, ahead_in;
   logic [WIDE_W-1:0] first_ff, first_in;
   logic [WIDE_W-1:0] next_ff, next_in;
   logic [31:0]       sreg_ff, sreg_in;
   logic [4:0]        mcnt_ff, mcnt_in;
   logic [3:0]        macc_ff, macc_in;
   logic              ok_ff, ok_in;
   logic              fired_ff, fired_in;
   logic [TIME_W-1:0] fired_t_ff, fired_t_in;

   div_cmd_type       div_cmd_ff, div_cmd_in;
   div_res_type       div_res;

   logic [PERIOD_W-1:0] full_ns;
   logic [WIDE_W-1:0]   now_w;
   logic [WIDE_W-1:0]   half_w;
   logic [WIDE_W-1:0]   period_w;
   logic [WIDE_W:0]     aln_diff;
   logic [31:0]         n32;
   logic [32:0]         slot_sum;
   logic [3:0]          macc_next;
   logic                is_marker;
   logic                wr_en;

   ptpg_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd_ff),
      .res   (div_res)
   );

   assign full_ns   = {half_ff, 1'b0};
   assign now_w     = {1'b0, now_ff};
   assign half_w    = {{(WIDE_W-HALF_W){1'b0}}, half_ff};
   assign period_w  = {{(WIDE_W-PERIOD_W){1'b0}}, full_ns};
   assign aln_diff  = {1'b0, ahead_ff} - {2'b00, cfg_anchor_ff};
   assign n32       = div_res.q_lo + 32'd1;
   assign slot_sum  = {29'd0, slot_ff} + {1'b0, n32};
   assign macc_next = mod10_step(macc_ff, sreg_ff[31]);
   assign is_marker = (apattern_ff != PAT_SILENT) && (apattern_ff != PAT_SQUARE);
   assign wr_en     = psel & penable & pwrite;

   assign pready = 1'b1;

   always_comb begin
      case (paddr)
         ADDR_PERIOD:  prdata = {32'd0, cfg_period_ff};
         ADDR_ANCHOR:  prdata = {1'b0, cfg_anchor_ff};
         ADDR_PATTERN: prdata = {62'd0, cfg_pattern_ff};
         default:      prdata = '0;
      endcase
   end

   always_comb begin
      cfg_period_in  = cfg_period_ff;
      cfg_anchor_in  = cfg_anchor_ff;
      cfg_pattern_in = cfg_pattern_ff;
      if (wr_en) begin
         case (paddr)
            ADDR_PERIOD:  cfg_period_in  = pwdata[31:0];
            ADDR_ANCHOR:  cfg_anchor_in  = pwdata[TIME_W-1:0];
            ADDR_PATTERN: cfg_pattern_in = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      running_in  = running_ff;
      pin_in      = pin_ff;
      target_in   = target_ff;
      slot_in     = slot_ff;
      fires_in    = fires_ff;
      missed_in   = missed_ff;
      aperiod_in  = aperiod_ff;
      apattern_in = apattern_ff;
      op_in       = op_ff;
      now_in      = now_ff;
      arm_in      = arm_ff;
      per_in      = per_ff;
      mtmp_in     = mtmp_ff;
      half_in     = half_ff;
      ahead_in    = ahead_ff;
      first_in    = first_ff;
      next_in     = next_ff;
      sreg_in     = sreg_ff;
      mcnt_in     = mcnt_ff;
      macc_in     = macc_ff;
      ok_in       = ok_ff;
      fired_in    = fired_ff;
      fired_t_in  = fired_t_ff;
      div_cmd_in  = div_cmd_ff;
      div_cmd_in.start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in      = req_ch.opcode;
               now_in     = req_ch.now_ns;
               arm_in     = req_ch.arm_accepted;
               ok_in      = 1'b0;
               fired_in   = 1'b0;
               fired_t_in = '0;
               state_in   = S_RESP;
               case (req_ch.opcode)
                  OP_START: begin
                     if (!running_ff && req_ch.clock_valid) begin
                        per_in   = (cfg_period_ff == 32'd0) ? DEFAULT_PERIOD_US
                                                            : cfg_period_ff;
                        state_in = S_MUL_A;
                     end
                  end
                  OP_FIRE: begin
                     if (running_ff) begin
                        per_in     = aperiod_ff;
                        fired_in   = 1'b1;
                        fired_t_in = target_ff[TIME_W-1:0];
                        state_in   = S_MUL_A;
                     end
                  end
                  OP_STOP: begin
                     if (running_ff) begin
                        running_in = 1'b0;
                        pin_in     = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // half period in ns: per*500 = per*512 - per*8 - per*4
         S_MUL_A: begin
            mtmp_in  = {per_ff, 9'd0} - {6'd0, per_ff, 3'd0};
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            half_in  = mtmp_ff - {7'd0, per_ff, 2'd0};
            state_in = (op_ff == OP_START) ? S_ALIGN : S_FIRE;
         end
         S_ALIGN: begin
            ahead_in = now_w + period_w;
            state_in = S_ALIGN2;
         end
         S_ALIGN2: begin
            if (cfg_anchor_ff == '0) begin
               first_in = ahead_ff;
               state_in = S_SLOT;
            end else if (aln_diff[WIDE_W] || (aln_diff == '0)) begin
               first_in = {1'b0, cfg_anchor_ff};
               state_in = S_SLOT;
            end else begin
               div_cmd_in.start    = 1'b1;
               div_cmd_in.dividend = aln_diff[WIDE_W-1:0];
               div_cmd_in.divisor  = full_ns;
               state_in = S_DIV_ALN;
            end
         end
         // round up to the next whole period past the anchor
         S_DIV_ALN: begin
            if (div_res.done) begin
               if (div_res.rem == '0) begin
                  first_in = ahead_ff;
               end else begin
                  first_in = ahead_ff + period_w
                           - {{(WIDE_W-PERIOD_W){1'b0}}, div_res.rem};
               end
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            div_cmd_in.start    = 1'b1;
            div_cmd_in.dividend = first_ff;
            div_cmd_in.divisor  = {1'b0, half_ff};
            state_in = S_DIV_SLOT;
         end
         S_DIV_SLOT: begin
            if (div_res.done) begin
               pin_in      = 1'b0;
               aperiod_in  = per_ff;
               apattern_in = cfg_pattern_ff;
               slot_in     = div_res.q_mod10;
               fires_in    = '0;
               missed_in   = '0;
               target_in   = first_ff;
               running_in  = arm_ff;
               ok_in       = arm_ff;
               state_in    = S_RESP;
            end
         end
         S_FIRE: begin
            if (apattern_ff == PAT_SQUARE) begin
               pin_in = ~pin_ff;
            end else if (is_marker) begin
               if (slot_ff == 4'd0) begin
                  pin_in = 1'b1;
               end else if (slot_ff == 4'd2) begin
                  pin_in = 1'b0;
               end
               slot_in = (slot_ff == 4'd9) ? 4'd0 : slot_ff + 4'd1;
            end
            next_in  = target_ff + half_w;
            state_in = S_FIRE2;
         end
         S_FIRE2: begin
            if ((next_ff <= now_w) && (half_ff != '0)) begin
               div_cmd_in.start    = 1'b1;
               div_cmd_in.dividend = now_w - next_ff;
               div_cmd_in.divisor  = {1'b0, half_ff};
               state_in = S_DIV_MISS;
            end else begin
               state_in = S_FIN;
            end
         end
         // catch up: next = now - ((now - next) mod half) + half
         S_DIV_MISS: begin
            if (div_res.done) begin
               next_in   = now_w - {{(WIDE_W-PERIOD_W){1'b0}}, div_res.rem} + half_w;
               missed_in = missed_ff + {32'd0, n32};
               sreg_in   = slot_sum[31:0];
               mcnt_in   = '0;
               macc_in   = '0;
               state_in  = is_marker ? S_MOD10 : S_FIN;
            end
         end
         S_MOD10: begin
            macc_in = macc_next;
            sreg_in = {sreg_ff[30:0], 1'b0};
            mcnt_in = mcnt_ff + 5'd1;
            if (mcnt_ff == 5'd31) begin
               slot_in  = macc_next;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (arm_ff) begin
               target_in = next_ff;
            end else begin
               target_in = now_w + half_w;
               missed_in = missed_ff + 64'd1;
            end
            fires_in = fires_ff + 64'd1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cfg_period_ff  <= '0;
         cfg_anchor_ff  <= '0;
         cfg_pattern_ff <= PAT_SQUARE;
         running_ff     <= 1'b0;
         pin_ff         <= 1'b0;
         target_ff      <= '0;
         slot_ff        <= '0;
         fires_ff       <= '0;
         missed_ff      <= '0;
         aperiod_ff     <= '0;
         apattern_ff    <= PAT_SQUARE;
         div_cmd_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         cfg_period_ff  <= cfg_period_in;
         cfg_anchor_ff  <= cfg_anchor_in;
         cfg_pattern_ff <= cfg_pattern_in;
         running_ff     <= running_in;
         pin_ff         <= pin_in;
         target_ff      <= target_in;
         slot_ff        <= slot_in;
         fires_ff       <= fires_in;
         missed_ff      <= missed_in;
         aperiod_ff     <= aperiod_in;
         apattern_ff    <= apattern_in;
         div_cmd_ff     <= div_cmd_in;
      end
      op_ff      <= op_in;
      now_ff     <= now_in;
      arm_ff     <= arm_in;
      per_ff     <= per_in;
      mtmp_ff    <= mtmp_in;
      half_ff    <= half_in;
      ahead_ff   <= ahead_in;
      first_ff   <= first_in;
      next_ff    <= next_in;
      sreg_ff    <= sreg_in;
      mcnt_ff    <= mcnt_in;
      macc_ff    <= macc_in;
      ok_ff      <= ok_in;
      fired_ff   <= fired_in;
      fired_t_ff <= fired_t_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   assign rsp_ch.valid           = (state_ff == S_RESP);
   assign rsp_ch.start_ok        = ok_ff;
   assign rsp_ch.is_running      = running_ff;
   assign rsp_ch.pin_level       = pin_ff;
   assign rsp_ch.target_ns       = target_ff[TIME_W-1:0];
   assign rsp_ch.fired_target_ns = fired_t_ff;
   assign rsp_ch.fired_valid     = fired_ff;
   assign rsp_ch.cycle_count     = fires_ff[TIME_W-1:0];
   assign rsp_ch.miss_count      = missed_ff[TIME_W-1:0];

endmodule
`default_nettype wire

FILE: src/ptpg_div.sv
// ptpg_div: bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module ptpg_div (
   input  wire                       clock,
   input  wire                       reset,
   input  ptpg_pkg::div_cmd_type     cmd,
   output ptpg_pkg::div_res_type     res
);
   import ptpg_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [WIDE_W-1:0]   dvd_ff, dvd_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [31:0]         qlo_ff, qlo_in;
   logic [3:0]          qm_ff, qm_in;

   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W+1:0] diff;
   logic                qbit;

   always_comb begin
      trial = {rem_ff, dvd_ff[WIDE_W-1]};
      diff  = {1'b0, trial} - {2'b00, dvs_ff};
      qbit  = ~diff[PERIOD_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      qlo_in  = qlo_ff;
      qm_in   = qm_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
         dvd_in  = cmd.dividend;
         dvs_in  = cmd.divisor;
         rem_in  = '0;
         qlo_in  = '0;
         qm_in   = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[WIDE_W-2:0], 1'b0};
         rem_in = qbit ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         qlo_in = {qlo_ff[30:0], qbit};
         qm_in  = mod10_step(qm_ff, qbit);
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      qlo_ff <= qlo_in;
      qm_ff  <= qm_in;
   end

   assign res.done    = done_ff;
   assign res.rem     = rem_ff;
   assign res.q_lo    = qlo_ff;
   assign res.q_mod10 = qm_ff;

endmodule
`default_nettype wire

FILE: verif/ptpg_checker.sv
// ptpg_checker: watches both channels and the register port, predicts each result and compares
`timescale 1ns / 1ps
module ptpg_checker (
   input  wire         clock,
   input  wire         reset,
   ptpg_req_if         req_ch,
   ptpg_rsp_if         rsp_ch,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [4:0]  paddr,
   input  wire  [63:0] pwdata,
   input  wire         pready,
   output int          fail_count,
   output int          pending
);
   import ptpg_pkg::*;

   typedef struct packed {
      logic        start_ok;
      logic        is_running;
      logic        pin_level;
      logic [62:0] target_ns;
      logic [62:0] fired_target_ns;
      logic        fired_valid;
      logic [62:0] cycle_count;
      logic [62:0] miss_count;
   } pulse_status_type;

   pulse_status_type expected_status_q[$];

   // register mirror
   logic [31:0] cfg_period;
   logic [62:0] cfg_anchor_ns;
   logic [1:0]  cfg_pattern;

   // generator state
   logic        running;
   logic        pin_state;
   logic [63:0] sched_target;
   logic [31:0] marker_slot;
   logic [63:0] fires_done;
   logic [63:0] slots_missed;
   logic [31:0] active_period;
   logic [1:0]  active_pattern;

   function automatic logic is_marker(input logic [1:0] p);
      return p != PAT_SILENT && p != PAT_SQUARE;
   endfunction

   task automatic start_generator(input logic [63:0] now, input logic cv, input logic arm,
                                  output logic ok);
      logic [31:0] per;
      logic [63:0] full_ns, half_ns, first, ahead, delta, n;
      ok = 1'b0;
      if (!running && cv) begin
         per = (cfg_period == 32'd0) ? 32'd1000 : cfg_period;
         pin_state = 1'b0;
         full_ns = 64'(per) * 64'd1000;
         half_ns = 64'(per) * 64'd500;
         ahead = now + full_ns;
         if (cfg_anchor_ns == 63'd0) begin
            first = ahead;
         end else if (64'(cfg_anchor_ns) >= ahead) begin
            first = 64'(cfg_anchor_ns);
         end else begin
            delta = ahead - 64'(cfg_anchor_ns);
            n = (delta + full_ns - 64'd1) / full_ns;
            first = 64'(cfg_anchor_ns) + n * full_ns;
         end
         active_period = per;
         active_pattern = cfg_pattern;
         marker_slot = 32'((first / half_ns) % 64'd10);
         fires_done = '0;
         slots_missed = '0;
         sched_target = first;
         running = arm;
         ok = arm;
      end
   endtask

   task automatic fire_generator(input logic [63:0] now, input logic arm);
      logic [63:0] half_ns, next, n;
      logic [31:0] slot_sum;
      half_ns = 64'(active_period) * 64'd500;
      if (active_pattern == PAT_SQUARE) begin
         pin_state = !pin_state;
      end else if (is_marker(active_pattern)) begin
         if (marker_slot == 32'd0) pin_state = 1'b1;
         else if (marker_slot == 32'd2) pin_state = 1'b0;
         marker_slot = (marker_slot + 32'd1) % 32'd10;
      end
      next = sched_target + half_ns;
      if (next <= now && half_ns != 64'd0) begin
         n = (now - next) / half_ns + 64'd1;
         next = next + n * half_ns;
         slots_missed = slots_missed + 64'(n[31:0]);
         if (is_marker(active_pattern)) begin
            slot_sum = marker_slot + n[31:0];
            marker_slot = slot_sum % 32'd10;
         end
      end
      sched_target = next;
      if (!arm) begin
         sched_target = now + half_ns;
         slots_missed = slots_missed + 64'd1;
      end
      fires_done = fires_done + 64'd1;
   endtask

   task automatic predict_event(input logic [1:0] op, input logic [62:0] now_ns,
                                input logic cv, input logic arm,
                                output pulse_status_type st);
      logic ok;
      st = '0;
      ok = 1'b0;
      case (op)
         OP_START: begin
            start_generator(64'(now_ns), cv, arm, ok);
         end
         OP_FIRE: begin
            if (running) begin
               st.fired_valid = 1'b1;
               st.fired_target_ns = sched_target[62:0];
               fire_generator(64'(now_ns), arm);
            end
         end
         OP_STOP: begin
            if (running) begin
               running = 1'b0;
               pin_state = 1'b0;
            end
         end
         default: ;
      endcase
      st.start_ok = ok;
      st.is_running = running;
      st.pin_level = pin_state;
      st.target_ns = sched_target[62:0];
      st.cycle_count = fires_done[62:0];
      st.miss_count = slots_missed[62:0];
   endtask

   task automatic check_field(input string name, input logic [62:0] exp_v,
                              input logic [62:0] act_v, inout logic bad);
      if (exp_v !== act_v) begin
         if (fail_count < 10) begin
            $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
         end
         bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      pulse_status_type st, act;
      logic bad;
      if (reset) begin
         cfg_period = '0;
         cfg_anchor_ns = '0;
         cfg_pattern = PAT_SQUARE;
         running = 1'b0;
         pin_state = 1'b0;
         sched_target = '0;
         marker_slot = '0;
         fires_done = '0;
         slots_missed = '0;
         active_period = '0;
         active_pattern = PAT_SQUARE;
         expected_status_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               ADDR_PERIOD:  cfg_period = pwdata[31:0];
               ADDR_ANCHOR:  cfg_anchor_ns = pwdata[62:0];
               ADDR_PATTERN: cfg_pattern = pwdata[1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            act = '{rsp_ch.start_ok, rsp_ch.is_running, rsp_ch.pin_level,
                    rsp_ch.target_ns, rsp_ch.fired_target_ns, rsp_ch.fired_valid,
                    rsp_ch.cycle_count, rsp_ch.miss_count};
            if (expected_status_q.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t result transaction with nothing expected", $realtime);
               end
               fail_count++;
            end else begin
               st = expected_status_q.pop_front();
               bad = 1'b0;
               check_field("start_ok", 63'(st.start_ok), 63'(act.start_ok), bad);
               check_field("is_running", 63'(st.is_running), 63'(act.is_running), bad);
               check_field("pin_level", 63'(st.pin_level), 63'(act.pin_level), bad);
               check_field("target_ns", st.target_ns, act.target_ns, bad);
               check_field("fired_target_ns", st.fired_target_ns, act.fired_target_ns, bad);
               check_field("fired_valid", 63'(st.fired_valid), 63'(act.fired_valid), bad);
               check_field("cycle_count", st.cycle_count, act.cycle_count, bad);
               check_field("miss_count", st.miss_count, act.miss_count, bad);
               if (bad) fail_count++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_event(req_ch.opcode, req_ch.now_ns, req_ch.clock_valid,
                          req_ch.arm_accepted, st);
            expected_status_q.push_back(st);
         end
      end
      pending = expected_status_q.size();
   end

endmodule

FILE: verif/tb_ptp_aligned_periodic_pulse_generator_top.sv
// tb_ptp_aligned_periodic_pulse_generator_top: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_ptp_aligned_periodic_pulse_generator_top;
   import ptpg_pkg::*;

   localparam logic [1:0] PAT_MARKER = 2'd2;
   localparam logic [1:0] PAT_MARKER_ALT = 2'd3;
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int ITEM_GOAL = 1950;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int STALL_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;
   int          fail_count, pending;
   int          send_idle_pct = 0;
   int          rcv_idle_pct = 0;
   int          item_count = 0;
   int          cycle_count = 0;
   logic        stall_go = 1'b0;
   logic [62:0] last_target = '0;
   logic [62:0] wall_ns = 63'd1000;
   logic [63:0] half_guess = 64'd500000;

   ptpg_req_if req_ch ();
   ptpg_rsp_if rsp_ch ();

   always #5 clock = ~clock;

   ptp_aligned_periodic_pulse_generator_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   ptpg_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_START;
      req_ch.now_ns = '0;
      req_ch.clock_valid = 1'b0;
      req_ch.arm_accepted = 1'b0;
      rsp_ch.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off
   int stall_left = 0;
   logic stall_done = 1'b0;
   always @(posedge clock) begin
      if (stall_go && !stall_done) begin
         stall_left = STALL_CYCLES;
         stall_done = 1'b1;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) last_target <= rsp_ch.target_ns;
   end

   task automatic reg_write(input logic [4:0] addr, input logic [63:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, then wait until every accepted transaction has its result
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] per, input logic [62:0] anchor,
                            input logic [1:0] pat);
      drain();
      reg_write(ADDR_PERIOD, 64'(per));
      reg_write(ADDR_ANCHOR, 64'(anchor));
      reg_write(ADDR_PATTERN, 64'(pat));
      half_guess = 64'(per == 32'd0 ? 32'd1000 : per) * 64'd500;
   endtask

   task automatic send_event(input logic [1:0] op, input logic [62:0] now,
                             input logic cv, input logic arm);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.now_ns <= now;
      req_ch.clock_valid <= cv;
      req_ch.arm_accepted <= arm;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      item_count++;
   endtask

   function automatic logic [62:0] rand63();
      return 63'({$urandom, $urandom});
   endfunction

   // a time around the scheduled target: on time, late by whole slots, early or anywhere
   function automatic logic [62:0] fire_time();
      logic [63:0] t;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: t = 64'(last_target) + 64'($urandom_range(0, 1000));
         6, 7: t = 64'(last_target) + half_guess * 64'($urandom_range(1, 20))
                   + 64'($urandom_range(0, 999));
         8: t = 64'(last_target) - 64'($urandom_range(0, 5000));
         default: t = $urandom_range(0, 1) ? 64'(rand63())
                      : 64'(last_target) + half_guess * (64'd1 << 33);
      endcase
      return t[62:0];
   endfunction

   task automatic run_sequence(input logic wait_fresh);
      int nfires;
      logic [62:0] now;
      now = $urandom_range(0, 7) == 0 ? rand63() : wall_ns;
      send_event(OP_START, now, $urandom_range(0, 15) != 0, $urandom_range(0, 11) != 0);
      nfires = $urandom_range(1, 12);
      for (int i = 0; i < nfires && item_count < ITEM_GOAL; i++) begin
         if (wait_fresh) drain();
         now = fire_time();
         send_event(OP_FIRE, now, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
         wall_ns = now;
      end
      if ($urandom_range(0, 4) != 0) begin
         send_event(OP_STOP, rand63(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end
      wall_ns = wall_ns + 63'($urandom_range(0, 100000));
   endtask

   task automatic run_phase(input int goal, input logic squeeze);
      while (item_count < goal) begin
         if (squeeze && !stall_go && item_count > goal - 200) begin
            stall_go <= 1'b1;
            repeat (3) run_sequence(1'b0);
         end else if ($urandom_range(0, 6) == 0) begin
            send_event(2'($urandom_range(0, 3)), rand63(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
         end else begin
            run_sequence(1'b1);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle events, failed starts, a normal run with catch-up and refused re-arm
      configure(32'd1, 63'd0, PAT_SQUARE);
      send_event(OP_FIRE, 63'd100, 1'b1, 1'b1);
      send_event(OP_STOP, 63'd100, 1'b1, 1'b1);
      send_event(OP_NONE, '1, 1'b1, 1'b1);
      send_event(OP_START, 63'd100, 1'b0, 1'b1);
      send_event(OP_START, 63'd100, 1'b1, 1'b0);
      send_event(OP_FIRE, 63'd2000, 1'b1, 1'b1);
      send_event(OP_START, 63'd0, 1'b1, 1'b1);
      send_event(OP_START, 63'd5, 1'b1, 1'b1);
      drain();
      send_event(OP_FIRE, last_target, 1'b1, 1'b1);
      drain();
      send_event(OP_FIRE, last_target + 63'd7777, 1'b0, 1'b1);
      drain();
      send_event(OP_FIRE, last_target, 1'b1, 1'b0);
      send_event(OP_NONE, 63'd0, 1'b0, 1'b0);
      send_event(OP_STOP, '1, 1'b0, 1'b0);
      configure(32'hFFFF_FFFF, '1, PAT_MARKER);
      send_event(OP_START, '1, 1'b1, 1'b1);
      drain();
      send_event(OP_FIRE, '1, 1'b1, 1'b1);
      send_event(OP_STOP, 63'd0, 1'b1, 1'b1);
      configure(32'd3, 63'd1, PAT_MARKER_ALT);
      send_event(OP_START, 63'h4000_0000_0000_0000, 1'b1, 1'b1);
      drain();
      send_event(OP_FIRE, last_target + 63'd1_000_000, 1'b1, 1'b1);
      send_event(OP_STOP, 63'd0, 1'b1, 1'b1);

      send_idle_pct = 27;
      rcv_idle_pct = 68;
      configure(32'd1, 63'd0, PAT_SQUARE);
      run_phase(330, 1'b1);
      configure(32'd3, rand63() >> 20, PAT_MARKER);
      run_phase(660, 1'b0);
      send_idle_pct = 68;
      rcv_idle_pct = 27;
      configure(32'hFFFF_FFFF, '1, PAT_SILENT);
      run_phase(900, 1'b0);
      configure(32'd7, 63'd12345, PAT_MARKER_ALT);
      run_phase(1250, 1'b0);
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      configure(32'd0, 63'h4000_0000_0000_0000, PAT_MARKER);
      run_phase(1600, 1'b0);
      configure(32'd2, 63'd1, PAT_SQUARE);
      run_phase(ITEM_GOAL, 1'b0);

      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
